// ----- hdl/sia_pkg.sv -----
package sia_pkg;

	localparam int KIND_W   = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD   = 4'd0,
		KIND_DIV   = 4'd1,
		KIND_MOD   = 4'd2,
		KIND_LESS  = 4'd3,
		KIND_EQUAL = 4'd4,
		KIND_MUL   = 4'd5,
		KIND_SUB   = 4'd6,
		KIND_OR    = 4'd7,
		KIND_AND   = 4'd8,
		KIND_SHIFT = 4'd9
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALUE = 2'd0,
		ST_TRUE  = 2'd1,
		ST_FALSE = 2'd2,
		ST_FAIL  = 2'd3
	} status_t;

	typedef struct packed {
		logic    valid;
		logic    use_quo;
		logic    use_rem;
		status_t status;
	} ctl_t;

endpackage

// ----- hdl/sia_if.sv -----
interface sia_req_if #(parameter int DATA_WIDTH = 32);
	logic                      valid;
	logic                      ready;
	logic [sia_pkg::KIND_W-1:0] kind;
	logic [DATA_WIDTH-1:0]     left_operand;
	logic [DATA_WIDTH-1:0]     right_operand;

	modport source (output valid, kind, left_operand, right_operand, input ready);
	modport sink (input valid, kind, left_operand, right_operand, output ready);
endinterface

interface sia_rsp_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic [sia_pkg::STATUS_W-1:0] status;
	logic [DATA_WIDTH-1:0]        value;

	modport source (output valid, status, value, input ready);
	modport sink (input valid, status, value, output ready);
endinterface

// ----- hdl/sia_front.sv -----
module sia_front #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  logic [sia_pkg::KIND_W-1:0]  kind,
	input  logic [DATA_WIDTH-1:0]       left_operand,
	input  logic [DATA_WIDTH-1:0]       right_operand,
	output sia_pkg::ctl_t               ctl_s1,
	output logic [DATA_WIDTH-1:0]       value_s1,
	output logic [DATA_WIDTH-1:0]       dividend_s1,
	output logic [DATA_WIDTH-1:0]       divisor_s1
);
	import sia_pkg::*;

	localparam int AW = $clog2(DATA_WIDTH);

	ctl_t                  ctl_d;
	logic [DATA_WIDTH-1:0] val_d;
	logic [DATA_WIDTH-1:0] amt;
	logic [DATA_WIDTH-1:0] shl;
	logic                  r_zero;

	always_comb begin
		amt    = (~right_operand) + DATA_WIDTH'(1);
		r_zero = (right_operand == '0);
		shl    = (right_operand >= DATA_WIDTH'(DATA_WIDTH)) ? '0
			: (left_operand << right_operand[AW-1:0]);
		ctl_d.valid   = in_valid;
		ctl_d.use_quo = 1'b0;
		ctl_d.use_rem = 1'b0;
		ctl_d.status  = ST_VALUE;
		val_d         = '0;
		case (kind)
			KIND_ADD: val_d = left_operand + right_operand;
			KIND_SUB: val_d = left_operand - right_operand;
			KIND_MUL: val_d = DATA_WIDTH'(left_operand * right_operand);
			KIND_OR:  val_d = left_operand | right_operand;
			KIND_AND: val_d = left_operand & right_operand;
			KIND_DIV: begin
				if (r_zero) ctl_d.status = ST_FAIL;
				else ctl_d.use_quo = 1'b1;
			end
			KIND_MOD: begin
				if (r_zero) ctl_d.status = ST_FAIL;
				else ctl_d.use_rem = 1'b1;
			end
			KIND_LESS:  ctl_d.status = (left_operand < right_operand) ? ST_TRUE : ST_FALSE;
			KIND_EQUAL: ctl_d.status = (left_operand == right_operand) ? ST_TRUE : ST_FALSE;
			KIND_SHIFT: begin
				if (right_operand[DATA_WIDTH-1]) begin
					val_d = (amt >= DATA_WIDTH'(DATA_WIDTH)) ? '0
						: (left_operand >> amt[AW-1:0]);
				end else if (left_operand > shl) begin
					ctl_d.status = ST_FAIL;
				end else begin
					val_d = shl;
				end
			end
			default: ctl_d.status = ST_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1    <= val_d;
			dividend_s1 <= left_operand;
			divisor_s1  <= right_operand;
		end
	end

endmodule

// ----- hdl/sia_div_stage.sv -----
module sia_div_stage #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  sia_pkg::ctl_t         ctl_in,
	input  logic [DATA_WIDTH-1:0] value_in,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	input  logic [DATA_WIDTH-1:0] dvs_in,
	output sia_pkg::ctl_t         ctl_s,
	output logic [DATA_WIDTH-1:0] value_s,
	output logic [DATA_WIDTH-1:0] rem_s,
	output logic [DATA_WIDTH-1:0] quo_s,
	output logic [DATA_WIDTH-1:0] dvs_s
);
	import sia_pkg::*;

	logic [DATA_WIDTH:0]   sh;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	always_comb begin
		sh   = {rem_in, quo_in[DATA_WIDTH-1]};
		diff = sh - {1'b0, dvs_in};
		ge   = (sh >= {1'b0, dvs_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else if (adv) begin
			ctl_s <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s <= value_in;
			dvs_s   <= dvs_in;
			rem_s   <= ge ? diff[DATA_WIDTH-1:0] : sh[DATA_WIDTH-1:0];
			quo_s   <= {quo_in[DATA_WIDTH-2:0], ge};
		end
	end

endmodule

// ----- hdl/small_integer_alu_top.sv -----
// Integer ALU: add, sub, mul, unsigned div/mod, less, equal, or, and, signed-amount
// shift. Fully pipelined: one item per cycle. An accepted item passes through the front
// register, DATA_WIDTH divider stages and the output register; the divider resolves
// one quotient bit per stage. All stages hold together while the output register is
// full and not taken.
module small_integer_alu_top #(
	parameter int DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	sia_req_if.sink   req,
	sia_rsp_if.source rsp
);
	import sia_pkg::*;

	logic                  adv;
	ctl_t                  ctl   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] val   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] dvs   [0:DATA_WIDTH];
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [DATA_WIDTH-1:0] out_value_q;

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;
	assign rem[0]    = '0;

	sia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (req.valid),
		.kind          (req.kind),
		.left_operand  (req.left_operand),
		.right_operand (req.right_operand),
		.ctl_s1        (ctl[0]),
		.value_s1      (val[0]),
		.dividend_s1   (quo[0]),
		.divisor_s1    (dvs[0])
	);

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_div
		sia_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl[i]),
			.value_in (val[i]),
			.rem_in   (rem[i]),
			.quo_in   (quo[i]),
			.dvs_in   (dvs[i]),
			.ctl_s    (ctl[i+1]),
			.value_s  (val[i+1]),
			.rem_s    (rem[i+1]),
			.quo_s    (quo[i+1]),
			.dvs_s    (dvs[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl[DATA_WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_status_q <= ctl[DATA_WIDTH].status;
			out_value_q  <= ctl[DATA_WIDTH].use_quo ? quo[DATA_WIDTH]
				: ctl[DATA_WIDTH].use_rem ? rem[DATA_WIDTH] : val[DATA_WIDTH];
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.value  = out_value_q;

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_VALUE |-> rsp.value == '0)
		else $error("nonzero value with non-value status");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.value) && $stable(rsp.status))
		else $error("output changed while stalled");

	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		ctl[DATA_WIDTH].valid |-> !(ctl[DATA_WIDTH].use_quo && ctl[DATA_WIDTH].use_rem)
			&& (!(ctl[DATA_WIDTH].use_quo || ctl[DATA_WIDTH].use_rem)
			|| ctl[DATA_WIDTH].status == ST_VALUE))
		else $error("bad divider select");

endmodule
